// ===== rtl/core/rsf_pkg.sv =====
// Shared types, widths and constants of the range/inertial speed fusion block.
// Used by the channel interfaces and every module under rtl/core.
package rsf_pkg;

    localparam int COUNT_BITS  = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam int DIST_W      = 16;
    localparam int RATE_W      = 16;
    localparam int ACC_W       = 16;
    localparam int TIME_W      = 32;
    localparam int VEL_W       = 31;
    localparam int FUSED_W     = 26;
    localparam int STAT_W      = 16;
    localparam int WEIGHT_W    = 7;
    localparam int SPEED_LIM_W = 20;
    localparam int SUM_W       = 39;
    localparam int VSUM_W      = 50;
    localparam int QUOT_W      = 25;
    localparam int DIVX_W      = 32;
    localparam int RECIP_W     = 33;
    localparam int PROD_W      = DIVX_W + RECIP_W;

    typedef enum logic [1:0] {
        MODE_RANGE    = 2'd0,
        MODE_INERTIAL = 2'd1,
        MODE_CLEAR    = 2'd2,
        MODE_IDLE     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_BRAKE   = 2'd1,
        EV_SPEEDUP = 2'd2,
        EV_TURN    = 2'd3
    } event_t;

    localparam logic [CFG_INDEX_W-1:0] REG_UWB_WEIGHT   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_IMU_WEIGHT   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_COLL_DIST    = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_COLL_SPEED   = CFG_INDEX_W'(3);

    localparam logic [WEIGHT_W-1:0]    RST_UWB_WEIGHT   = WEIGHT_W'(70);
    localparam logic [WEIGHT_W-1:0]    RST_IMU_WEIGHT   = WEIGHT_W'(30);
    localparam logic [DIST_W-1:0]      RST_COLL_DIST    = DIST_W'(500);
    localparam logic [SPEED_LIM_W-1:0] RST_COLL_SPEED   = SPEED_LIM_W'(5000);

    localparam logic [13:0]                UWB_SCALE  = 14'd100;
    localparam logic signed [VSUM_W-1:0]   VEL_MAX    = VSUM_W'(1000000000);
    localparam logic signed [VSUM_W-1:0]   VEL_MIN    = -VSUM_W'(1000000000);
    localparam logic signed [FUSED_W-1:0]  FUSED_MAX  = FUSED_W'(31000000);
    localparam logic signed [FUSED_W-1:0]  FUSED_MIN  = -FUSED_W'(31000000);
    localparam logic [QUOT_W-1:0]          QUOT_LIMIT = QUOT_W'(31000000);

    // Division by 1000 is a shift by 3 followed by a reciprocal multiply for 125.
    localparam logic [SUM_W-1:0]   DIV_LIMIT = SUM_W'(64'd31000000000);
    localparam int                 DIV_PRE   = 3;
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(64'd4398046512);
    localparam int                 DIV_SHIFT = 39;

    typedef struct packed {
        logic [1:0]              mode;
        logic [DIST_W-1:0]       filtered_distance_mm;
        logic signed [RATE_W-1:0] range_rate_mm_s;
        logic signed [ACC_W-1:0] forward_accel_cms2;
        logic [ACC_W-1:0]        accel_magnitude_cms2;
        logic [1:0]              motion_event;
        logic [TIME_W-1:0]       sample_time_ms;
    } sample_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0]    uwb_weight;
        logic [WEIGHT_W-1:0]    imu_weight;
        logic [DIST_W-1:0]      coll_dist;
        logic [SPEED_LIM_W-1:0] coll_speed;
    } cfg_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] velocity;
        logic [STAT_W-1:0]       peak;
        logic [STAT_W-1:0]       brake;
        logic [STAT_W-1:0]       speedup;
        logic [STAT_W-1:0]       turn;
    } stat_t;

    typedef struct packed {
        logic                    is_range;
        logic [DIST_W-1:0]       range_mm;
        logic signed [SUM_W-1:0] sum;
    } fuse_req_t;

endpackage

// ===== rtl/core/rsf_if.sv =====
// Channel interfaces of the range/inertial speed fusion block: sample input,
// result output and register write port. Depends on rsf_pkg.
interface rsf_in_if import rsf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               mode;
    logic [DIST_W-1:0]        filtered_distance_mm;
    logic signed [RATE_W-1:0] range_rate_mm_s;
    logic signed [ACC_W-1:0]  forward_accel_cms2;
    logic [ACC_W-1:0]         accel_magnitude_cms2;
    logic [1:0]               motion_event;
    logic [TIME_W-1:0]        sample_time_ms;

    modport source (
        output valid, mode, filtered_distance_mm, range_rate_mm_s, forward_accel_cms2,
        output accel_magnitude_cms2, motion_event, sample_time_ms,
        input  ready
    );
    modport sink (
        input  valid, mode, filtered_distance_mm, range_rate_mm_s, forward_accel_cms2,
        input  accel_magnitude_cms2, motion_event, sample_time_ms,
        output ready
    );
endinterface

interface rsf_out_if import rsf_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [FUSED_W-1:0] fused_speed;
    logic                      risk_flag;
    logic signed [VEL_W-1:0]   forward_velocity;
    logic [STAT_W-1:0]         peak_accel_cms2;
    logic [STAT_W-1:0]         brake_events;
    logic [STAT_W-1:0]         speedup_events;
    logic [STAT_W-1:0]         turn_events;

    modport source (
        output valid, fused_speed, risk_flag, forward_velocity, peak_accel_cms2,
        output brake_events, speedup_events, turn_events,
        input  ready
    );
    modport sink (
        input  valid, fused_speed, risk_flag, forward_velocity, peak_accel_cms2,
        input  brake_events, speedup_events, turn_events,
        output ready
    );
endinterface

interface rsf_cfg_if import rsf_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/range_inertial_speed_fusion.sv =====
// Top level of the range/inertial speed fusion block: input register,
// configuration registers, state stage and fusion pipeline.
// Depends on rsf_pkg, rsf_if, rsf_stats and rsf_fuse.
//
//  Channel  | Modport | Transaction
//  ---------+---------+--------------------------------------------------
//  sample   | sink    | one range or inertial sample, clear or idle command
//  result   | source  | one result per sample transaction, in order
//  cfg      | sink    | one register write (index, data)
//
// One transaction is accepted per cycle while the result is not stalled; the
// pipeline has five register stages: input, state and three fusion stages.
// The rate is set by the state stage, where the 16x33 integrator multiply,
// the add and the clamp close the loop on the velocity register.
// Reset clears all valid bits and statistics and loads register defaults.
// A stalled result holds every stage behind it; empty stages still fill.
module range_inertial_speed_fusion import rsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rsf_in_if.sink     sample,
    rsf_out_if.source  result,
    rsf_cfg_if.sink    cfg
);

    logic      v0_reg, v1_reg;
    sample_t   item_reg;
    cfg_t      cfg_reg, cfg_next;
    logic      rdy0, rdy1, fuse_ready;
    logic      load0, load1;
    stat_t     stat;
    fuse_req_t req;
    stat_t     out_stat;

    assign rdy1         = !v1_reg || fuse_ready;
    assign rdy0         = !v0_reg || rdy1;
    assign load0        = sample.valid && rdy0;
    assign load1        = v0_reg && rdy1;
    assign sample.ready = rdy0;
    assign cfg.ready    = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        case (cfg.index)
            REG_UWB_WEIGHT: cfg_next.uwb_weight = WEIGHT_W'(cfg.data);
            REG_IMU_WEIGHT: cfg_next.imu_weight = WEIGHT_W'(cfg.data);
            REG_COLL_DIST:  cfg_next.coll_dist  = DIST_W'(cfg.data);
            REG_COLL_SPEED: cfg_next.coll_speed = SPEED_LIM_W'(cfg.data);
            default:        ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg             <= 1'b0;
            v1_reg             <= 1'b0;
            cfg_reg.uwb_weight <= RST_UWB_WEIGHT;
            cfg_reg.imu_weight <= RST_IMU_WEIGHT;
            cfg_reg.coll_dist  <= RST_COLL_DIST;
            cfg_reg.coll_speed <= RST_COLL_SPEED;
        end
        else
        begin
            if (rdy0)
                v0_reg <= sample.valid;
            if (rdy1)
                v1_reg <= v0_reg;
            if (cfg.valid)
                cfg_reg <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load0)
        begin
            item_reg.mode                 <= sample.mode;
            item_reg.filtered_distance_mm <= sample.filtered_distance_mm;
            item_reg.range_rate_mm_s      <= sample.range_rate_mm_s;
            item_reg.forward_accel_cms2   <= sample.forward_accel_cms2;
            item_reg.accel_magnitude_cms2 <= sample.accel_magnitude_cms2;
            item_reg.motion_event         <= sample.motion_event;
            item_reg.sample_time_ms       <= sample.sample_time_ms;
        end
    end

    rsf_stats u_stats
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load1),
        .item     (item_reg),
        .cfg_regs (cfg_reg),
        .stat     (stat),
        .req      (req)
    );

    rsf_fuse u_fuse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1_reg),
        .in_ready  (fuse_ready),
        .req       (req),
        .stat      (stat),
        .cfg_regs  (cfg_reg),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .fused     (result.fused_speed),
        .risk      (result.risk_flag),
        .out_stat  (out_stat)
    );

    assign result.forward_velocity = out_stat.velocity;
    assign result.peak_accel_cms2  = out_stat.peak;
    assign result.brake_events     = out_stat.brake;
    assign result.speedup_events   = out_stat.speedup;
    assign result.turn_events      = out_stat.turn;

endmodule

// ===== rtl/core/rsf_stats.sv =====
// State stage: velocity integrator, peak hold, event counters and the fusion sum.
// Depends on rsf_pkg.
module rsf_stats import rsf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  sample_t   item,
    input  cfg_t      cfg_regs,
    output stat_t     stat,
    output fuse_req_t req
);

    logic signed [VEL_W-1:0]  vel_reg, vel_next;
    logic [TIME_W-1:0]        last_time_reg, last_time_next;
    logic                     started_reg, started_next;
    logic [ACC_W-1:0]         peak_reg, peak_next;
    event_t                   prev_event_reg, prev_event_next;
    logic [COUNT_BITS-1:0]    brake_reg, brake_next;
    logic [COUNT_BITS-1:0]    speedup_reg, speedup_next;
    logic [COUNT_BITS-1:0]    turn_reg, turn_next;
    fuse_req_t                req_reg, req_next;

    mode_t                    mode;
    event_t                   ev;
    logic [TIME_W-1:0]        dt;
    logic signed [48:0]       prod;
    logic signed [VSUM_W-1:0] vsum;
    logic [13:0]              uwb_scaled;
    logic signed [30:0]       rate_term;
    logic signed [SUM_W-1:0]  vel_term;

    assign mode       = mode_t'(item.mode);
    assign ev         = event_t'(item.motion_event);
    assign dt         = item.sample_time_ms - last_time_reg;
    assign prod       = item.forward_accel_cms2 * $signed({1'b0, dt});
    assign vsum       = VSUM_W'(prod) + VSUM_W'(vel_reg);
    assign uwb_scaled = 14'(cfg_regs.uwb_weight) * UWB_SCALE;
    assign rate_term  = $signed({1'b0, uwb_scaled}) * item.range_rate_mm_s;
    assign vel_term   = $signed({1'b0, cfg_regs.imu_weight}) * vel_reg;

    always_comb
    begin
        vel_next        = vel_reg;
        last_time_next  = last_time_reg;
        started_next    = started_reg;
        peak_next       = peak_reg;
        prev_event_next = prev_event_reg;
        brake_next      = brake_reg;
        speedup_next    = speedup_reg;
        turn_next       = turn_reg;
        case (mode)
            MODE_INERTIAL:
            begin
                if (started_reg)
                begin
                    if (vsum > VEL_MAX)
                        vel_next = VEL_W'(VEL_MAX);
                    else if (vsum < VEL_MIN)
                        vel_next = VEL_W'(VEL_MIN);
                    else
                        vel_next = VEL_W'(vsum);
                end
                last_time_next = item.sample_time_ms;
                started_next   = 1'b1;
                if (item.accel_magnitude_cms2 > peak_reg)
                    peak_next = item.accel_magnitude_cms2;
                if (ev != EV_NONE && ev != prev_event_reg)
                begin
                    case (ev)
                        EV_BRAKE:
                            brake_next = (brake_reg == '1) ? brake_reg : brake_reg + 1'b1;
                        EV_SPEEDUP:
                            speedup_next = (speedup_reg == '1) ? speedup_reg
                                                               : speedup_reg + 1'b1;
                        EV_TURN:
                            turn_next = (turn_reg == '1) ? turn_reg : turn_reg + 1'b1;
                        default:
                            ;
                    endcase
                end
                prev_event_next = ev;
            end
            MODE_CLEAR:
            begin
                vel_next     = '0;
                started_next = 1'b0;
                peak_next    = '0;
                brake_next   = '0;
                speedup_next = '0;
                turn_next    = '0;
            end
            default:
                ;
        endcase
    end

    always_comb
    begin
        req_next.is_range = (mode == MODE_RANGE);
        req_next.range_mm = item.filtered_distance_mm;
        req_next.sum      = SUM_W'(rate_term) + vel_term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_reg        <= '0;
            last_time_reg  <= '0;
            started_reg    <= 1'b0;
            peak_reg       <= '0;
            prev_event_reg <= EV_NONE;
            brake_reg      <= '0;
            speedup_reg    <= '0;
            turn_reg       <= '0;
        end
        else if (load)
        begin
            vel_reg        <= vel_next;
            last_time_reg  <= last_time_next;
            started_reg    <= started_next;
            peak_reg       <= peak_next;
            prev_event_reg <= prev_event_next;
            brake_reg      <= brake_next;
            speedup_reg    <= speedup_next;
            turn_reg       <= turn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            req_reg <= req_next;
    end

    assign req           = req_reg;
    assign stat.velocity = vel_reg;
    assign stat.peak     = STAT_W'(peak_reg);
    assign stat.brake    = STAT_W'(brake_reg);
    assign stat.speedup  = STAT_W'(speedup_reg);
    assign stat.turn     = STAT_W'(turn_reg);

endmodule

// ===== rtl/core/rsf_fuse.sv =====
// Fusion pipeline: magnitude and range check, reciprocal multiply for the
// division by 1000, then the result register with fused speed and risk hold.
// Depends on rsf_pkg.
module rsf_fuse import rsf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  fuse_req_t                 req,
    input  stat_t                     stat,
    input  cfg_t                      cfg_regs,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic signed [FUSED_W-1:0] fused,
    output logic                      risk,
    output stat_t                     out_stat
);

    logic                      v2_reg, v3_reg, v4_reg;
    logic                      rdy2, rdy3, rdy4;
    logic                      load2, load3, load4;

    logic                      is_range2_reg, is_range3_reg;
    logic [DIST_W-1:0]         dist2_reg, dist3_reg;
    logic                      neg2_reg, neg3_reg;
    logic                      over2_reg, over3_reg;
    logic [DIVX_W-1:0]         x2_reg;
    logic [PROD_W-1:0]         prod3_reg, prod3_next;
    stat_t                     stat2_reg, stat3_reg, stat4_reg;

    logic signed [FUSED_W-1:0] fused_hold_reg, fused_hold_next;
    logic                      risk_hold_reg, risk_hold_next;

    logic [SUM_W-1:0]          mag;
    logic [QUOT_W-1:0]         quot;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign in_ready = rdy2;
    assign load2    = rdy2 && in_valid;
    assign load3    = rdy3 && v2_reg;
    assign load4    = rdy4 && v3_reg;

    assign mag        = req.sum[SUM_W-1] ? SUM_W'(-req.sum) : SUM_W'(req.sum);
    assign prod3_next = PROD_W'(x2_reg) * PROD_W'(DIV_RECIP);
    assign quot       = over3_reg ? QUOT_LIMIT : prod3_reg[DIV_SHIFT +: QUOT_W];

    always_comb
    begin
        fused_hold_next = fused_hold_reg;
        risk_hold_next  = risk_hold_reg;
        if (is_range3_reg)
        begin
            fused_hold_next = neg3_reg ? -FUSED_W'(quot) : FUSED_W'(quot);
            risk_hold_next  = (dist3_reg < cfg_regs.coll_dist) &&
                              (quot > QUOT_W'(cfg_regs.coll_speed));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            fused_hold_reg <= '0;
            risk_hold_reg  <= 1'b0;
        end
        else
        begin
            if (rdy2)
                v2_reg <= in_valid;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
            if (load4)
            begin
                fused_hold_reg <= fused_hold_next;
                risk_hold_reg  <= risk_hold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            is_range2_reg <= req.is_range;
            dist2_reg     <= req.range_mm;
            neg2_reg      <= req.sum[SUM_W-1];
            over2_reg     <= (mag >= DIV_LIMIT);
            x2_reg        <= mag[DIV_PRE +: DIVX_W];
            stat2_reg     <= stat;
        end
        if (load3)
        begin
            is_range3_reg <= is_range2_reg;
            dist3_reg     <= dist2_reg;
            neg3_reg      <= neg2_reg;
            over3_reg     <= over2_reg;
            prod3_reg     <= prod3_next;
            stat3_reg     <= stat2_reg;
        end
        if (load4)
            stat4_reg <= stat3_reg;
    end

    assign out_valid = v4_reg;
    assign fused     = fused_hold_reg;
    assign risk      = risk_hold_reg;
    assign out_stat  = stat4_reg;

`ifndef NO_ASSERTIONS
    a_fused_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fused_hold_reg <= FUSED_MAX) && (fused_hold_reg >= FUSED_MIN))
        else $error("Fused speed left its saturation range.");

    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !over3_reg) |-> (prod3_reg[DIV_SHIFT +: QUOT_W] < QUOT_LIMIT))
        else $error("Quotient exceeds the limit without the saturation flag.");

    a_risk_needs_speed: assert property (@(posedge clk) disable iff (!rst_n)
        risk_hold_reg |-> (fused_hold_reg != '0))
        else $error("Collision risk held with zero fused speed.");

    a_hold_on_other: assert property (@(posedge clk) disable iff (!rst_n)
        (load4 && !is_range3_reg) |=> ($stable(fused_hold_reg) && $stable(risk_hold_reg)))
        else $error("Fused hold changed on a transaction that is not a range sample.");
`endif

endmodule
